/* rtl/pftws_pkg.sv */
// ----------------------------------------------------------------------------
// pftws_pkg
// Shared types and constants of the per-track feature window store.
// ----------------------------------------------------------------------------
package pftws_pkg;

    localparam int DEF_MAX_TRACKS   = 16;
    localparam int DEF_MAX_FEATURES = 8;
    localparam int DEF_MAX_FRAMES   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_LIMIT    = 2'd2;

    localparam logic [1:0] STATUS_DATA      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;

    localparam logic ACTION_ADD  = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CLEAR,
        ST_MOD,
        ST_WRITE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_OUT
    } state_t;

endpackage

/* rtl/per_track_feature_window_store_core.sv */
// ----------------------------------------------------------------------------
// per_track_feature_window_store_core
// Track table with a sliding window of feature vectors per track.
//
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid / s_tready   tdata {feature_word, track_id}, tuser action,
//                                     tlast vector_end
// m_       out  m_tvalid / m_tready   tdata window_word, tuser {newly_created, status},
//                                     tlast burst_end
// cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Feature words and ticks are taken one per cycle while idle. A completed vector
// passes through a lookup, a wrap of the oldest pointer modulo frame_count, one
// feature word written per cycle, then an address, a data and an output-request
// state per window word on the window RAM. A new track first clears its window
// region of MAX_FRAMES * MAX_FEATURES words.
// Reset (aresetn low, synchronous) empties the table and the staging buffer.
// A stalled output request holds the sequencer; no input is taken meanwhile.
// ----------------------------------------------------------------------------
module per_track_feature_window_store_core #(
    parameter int MAX_TRACKS   = pftws_pkg::DEF_MAX_TRACKS,
    parameter int MAX_FEATURES = pftws_pkg::DEF_MAX_FEATURES,
    parameter int MAX_FRAMES   = pftws_pkg::DEF_MAX_FRAMES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [47:0]                       s_tdata,   // [15:0] track_id, [47:16] feature_word
    input  logic                              s_tuser,   // [0] action
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [31:0] window_word
    output logic [2:0]                        m_tuser,   // [1:0] status, [2] newly_created
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pftws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pftws_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import pftws_pkg::*;

    localparam int ENTRY_WORDS = MAX_FRAMES * MAX_FEATURES;
    localparam int MEM_DEPTH   = MAX_TRACKS * ENTRY_WORDS;
    localparam int EW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int FI  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int SW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int PW  = (ENTRY_WORDS > 1) ? $clog2(ENTRY_WORDS) : 1;
    localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNW = $clog2(MAX_FEATURES + 2);

    // configuration
    logic [3:0]  feat_cnt_reg, frame_cnt_reg;
    logic [15:0] life_reg;

    // track table
    logic                entry_valid_reg [MAX_TRACKS];
    logic                entry_valid_next[MAX_TRACKS];
    logic [15:0]         entry_track_reg [MAX_TRACKS];
    logic [15:0]         entry_track_next[MAX_TRACKS];
    logic [15:0]         entry_idle_reg  [MAX_TRACKS];
    logic [15:0]         entry_idle_next [MAX_TRACKS];
    logic                entry_ref_reg   [MAX_TRACKS];
    logic                entry_ref_next  [MAX_TRACKS];
    logic [SW-1:0]       entry_old_reg   [MAX_TRACKS];
    logic [SW-1:0]       entry_old_next  [MAX_TRACKS];

    // staging buffer
    logic [31:0]         stage_reg [MAX_FEATURES];
    logic [CNW-1:0]      stage_cnt_reg, stage_cnt_next;
    logic [CNW-1:0]      cnt_inc;
    logic                len_ok_reg, len_ok_next;
    logic [15:0]         id_reg, id_next;

    // sequencer
    state_t              state_reg, state_next;
    logic [EW-1:0]       ent_reg, ent_next;
    logic                created_reg, created_next;
    logic [SW-1:0]       slot_reg, slot_next;
    logic [FI-1:0]       f_reg, f_next;
    logic [SW-1:0]       k_reg, k_next;
    logic [PW-1:0]       ptr_reg, ptr_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_word_reg, out_word_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic                out_new_reg, out_new_next;
    logic                out_last_reg, out_last_next;

    // window RAM
    logic [31:0]         mem [MEM_DEPTH];
    logic [31:0]         mem_rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [31:0]         mem_wdata;

    logic [7:0]          nf8, nr8;
    logic                s_fire, m_fire;
    logic                hit, free_found;
    logic [EW-1:0]       hit_idx, free_idx;
    logic [SW-1:0]       slot_inc;
    logic                word_last;
    logic [31:0]         rd_addr_full, wr_addr_full, clr_addr_full;

    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_word_reg;
    assign m_tuser   = {out_new_reg, out_status_reg};
    assign m_tlast   = out_last_reg;

    // clamp register values into 1..MAX
    always_comb begin
        if (feat_cnt_reg == 4'd0) begin
            nf8 = 8'd1;
        end else if (8'(feat_cnt_reg) > 8'(MAX_FEATURES)) begin
            nf8 = 8'(MAX_FEATURES);
        end else begin
            nf8 = 8'(feat_cnt_reg);
        end
        if (frame_cnt_reg == 4'd0) begin
            nr8 = 8'd1;
        end else if (8'(frame_cnt_reg) > 8'(MAX_FRAMES)) begin
            nr8 = 8'(MAX_FRAMES);
        end else begin
            nr8 = 8'(frame_cnt_reg);
        end
    end

    // lowest matching entry and lowest free entry
    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int e = MAX_TRACKS - 1; e >= 0; e--) begin
            if (entry_valid_reg[e] && entry_track_reg[e] == id_reg) begin
                hit     = 1'b1;
                hit_idx = EW'(e);
            end
            if (!entry_valid_reg[e]) begin
                free_found = 1'b1;
                free_idx   = EW'(e);
            end
        end
    end

    assign cnt_inc   = (32'(stage_cnt_reg) <= MAX_FEATURES) ? stage_cnt_reg + 1'b1 : stage_cnt_reg;
    assign slot_inc  = (8'(slot_reg) + 8'd1 == nr8) ? '0 : slot_reg + 1'b1;
    assign word_last = (8'(k_reg) + 8'd1 == nr8) && (8'(f_reg) + 8'd1 == nf8);

    assign wr_addr_full  = 32'(ent_reg) * ENTRY_WORDS + 32'(slot_reg) * MAX_FEATURES + 32'(f_reg);
    assign rd_addr_full  = wr_addr_full;
    assign clr_addr_full = 32'(ent_reg) * ENTRY_WORDS + 32'(ptr_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == ACTION_ADD && s_tlast) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!len_ok_reg || (!hit && !free_found)) begin
                    state_next = ST_OUT;
                end else if (!hit) begin
                    state_next = ST_CLEAR;
                end else begin
                    state_next = ST_MOD;
                end
            end
            ST_CLEAR: begin
                if (32'(ptr_reg) == ENTRY_WORDS - 1) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (8'(slot_reg) < nr8) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (8'(f_reg) + 8'd1 == nf8) begin
                    state_next = ST_RD_ADDR;
                end
            end
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_OUT;
            ST_OUT: begin
                if (m_fire) begin
                    state_next = out_last_reg ? ST_IDLE : ST_RD_ADDR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        for (int e = 0; e < MAX_TRACKS; e++) begin
            entry_valid_next[e] = entry_valid_reg[e];
            entry_track_next[e] = entry_track_reg[e];
            entry_idle_next[e]  = entry_idle_reg[e];
            entry_ref_next[e]   = entry_ref_reg[e];
            entry_old_next[e]   = entry_old_reg[e];
        end
        stage_cnt_next  = stage_cnt_reg;
        len_ok_next     = len_ok_reg;
        id_next         = id_reg;
        ent_next        = ent_reg;
        created_next    = created_reg;
        slot_next       = slot_reg;
        f_next          = f_reg;
        k_next          = k_reg;
        ptr_next        = ptr_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_new_next    = out_new_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_addr_full[AW-1:0];
        mem_wdata       = stage_reg[f_reg];
        mem_raddr       = rd_addr_full[AW-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_tuser == ACTION_TICK) begin
                    // age every unreferenced live entry, reset referenced ones, evict the stale ones
                    for (int e = 0; e < MAX_TRACKS; e++) begin
                        if (entry_valid_reg[e]) begin
                            if (entry_ref_reg[e]) begin
                                entry_idle_next[e] = '0;
                                entry_ref_next[e]  = 1'b0;
                            end else begin
                                entry_idle_next[e] = (entry_idle_reg[e] != 16'hFFFF) ?
                                                     entry_idle_reg[e] + 16'd1 : entry_idle_reg[e];
                                if (entry_idle_next[e] > life_reg) begin
                                    entry_valid_next[e] = 1'b0;
                                end
                            end
                        end
                    end
                end else if (s_fire) begin
                    if (s_tlast) begin
                        len_ok_next    = (8'(cnt_inc) == nf8);
                        id_next        = s_tdata[15:0];
                        stage_cnt_next = '0;
                    end else begin
                        stage_cnt_next = cnt_inc;
                    end
                end
            end
            ST_LOOKUP: begin
                f_next   = '0;
                ptr_next = '0;
                if (!len_ok_reg || (!hit && !free_found)) begin
                    out_valid_next  = 1'b1;
                    out_word_next   = '0;
                    out_status_next = !len_ok_reg ? STATUS_BAD_LEN : STATUS_TABLE_FULL;
                    out_new_next    = 1'b0;
                    out_last_next   = 1'b1;
                end else if (hit) begin
                    ent_next     = hit_idx;
                    created_next = 1'b0;
                    slot_next    = entry_old_reg[hit_idx];
                end else begin
                    // claim the free entry
                    ent_next                   = free_idx;
                    created_next               = 1'b1;
                    slot_next                  = '0;
                    entry_valid_next[free_idx] = 1'b1;
                    entry_track_next[free_idx] = id_reg;
                    entry_idle_next[free_idx]  = '0;
                end
            end
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_full[AW-1:0];
                mem_wdata = '0;
                ptr_next  = ptr_reg + 1'b1;
            end
            ST_MOD: begin
                if (8'(slot_reg) >= nr8) begin
                    slot_next = SW'(8'(slot_reg) - nr8);
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                f_next = f_reg + 1'b1;
                if (8'(f_reg) + 8'd1 == nf8) begin
                    f_next                  = '0;
                    k_next                  = '0;
                    slot_next               = slot_inc;
                    entry_old_next[ent_reg] = slot_inc;
                    entry_ref_next[ent_reg] = 1'b1;
                end
            end
            ST_RD_DATA: begin
                out_valid_next  = 1'b1;
                out_word_next   = mem_rdata_reg;
                out_status_next = STATUS_DATA;
                out_new_next    = created_reg;
                out_last_next   = word_last;
            end
            ST_OUT: begin
                if (m_fire) begin
                    out_valid_next = 1'b0;
                    // advance to the next word of the ring
                    if (8'(f_reg) + 8'd1 == nf8) begin
                        f_next    = '0;
                        k_next    = k_reg + 1'b1;
                        slot_next = slot_inc;
                    end else begin
                        f_next = f_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            stage_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            feat_cnt_reg  <= 4'd8;
            frame_cnt_reg <= 4'd8;
            life_reg      <= 16'd10;
            for (int e = 0; e < MAX_TRACKS; e++) begin
                entry_valid_reg[e] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            stage_cnt_reg <= stage_cnt_next;
            out_valid_reg <= out_valid_next;
            for (int e = 0; e < MAX_TRACKS; e++) begin
                entry_valid_reg[e] <= entry_valid_next[e];
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FEATURE_COUNT: feat_cnt_reg  <= cfg_data[3:0];
                    CFG_FRAME_COUNT:   frame_cnt_reg <= cfg_data[3:0];
                    CFG_LIFE_LIMIT:    life_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        for (int e = 0; e < MAX_TRACKS; e++) begin
            entry_track_reg[e] <= entry_track_next[e];
            entry_idle_reg[e]  <= entry_idle_next[e];
            entry_ref_reg[e]   <= entry_ref_next[e];
            entry_old_reg[e]   <= entry_old_next[e];
        end
        if (s_fire && s_tuser == ACTION_ADD && 32'(stage_cnt_reg) < MAX_FEATURES) begin
            stage_reg[stage_cnt_reg[FI-1:0]] <= s_tdata[47:16];
        end
        len_ok_reg     <= len_ok_next;
        id_reg         <= id_next;
        ent_reg        <= ent_next;
        created_reg    <= created_next;
        slot_reg       <= slot_next;
        f_reg          <= f_next;
        k_reg          <= k_next;
        ptr_reg        <= ptr_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_new_reg    <= out_new_next;
        out_last_reg   <= out_last_next;
    end

    // window RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

endmodule
